// ===== sv/wvm_pkg.sv =====
// Shared types, codes and constants of the wavetable voice mixer.
package wvm_pkg;

    localparam int CHANNELS_DEF      = 8;
    localparam int SAMPLE_SLOTS_DEF  = 32;
    localparam int FRAC_BITS_DEF     = 12;
    localparam int MEM_ADDR_BITS_DEF = 17;

    localparam int OUT_BITS   = 8;
    localparam int SUM_W      = 16;
    localparam int ADDR_W     = 17;
    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int PAN_FULL  = 128;
    localparam int GAIN_MAX  = 64;
    localparam int VOL_SHIFT = 6;
    localparam int OUT_BIAS  = 128;

    localparam logic [1:0] MODE_MEM   = 2'd0;
    localparam logic [1:0] MODE_DESC  = 2'd1;
    localparam logic [1:0] MODE_VOICE = 2'd2;
    localparam logic [1:0] MODE_GEN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PTR,
        S_RD_CUR,
        S_RD_NXT,
        S_INTERP,
        S_MIX,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [7:0]        mem_byte;
        logic [4:0]        sample_index;
        logic [ADDR_W-1:0] region_end;
        logic [ADDR_W-1:0] loop_length;
        logic [2:0]        channel;
        logic [15:0]       step;
        logic [6:0]        volume;
        logic [7:0]        panning;
        logic              restart;
        logic [15:0]       start_offset;
    } t_item;

    typedef struct packed {
        logic write;
        logic start;
        logic load;
        logic ptr;
        logic rd_cur;
        logic rd_nxt;
        logic interp;
        logic mix;
        logic next_voice;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip_voice;
        logic last_voice;
        logic div_last;
        logic out_busy;
    } t_sts;

endpackage

// ===== sv/wvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/wvm_ctrl.sv =====
// Sequencer of the mixer: accepts beats and steps the datapath through each voice.
module wvm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    input  logic [1:0]    i_mode,
    output logic          o_tready,
    input  wvm_pkg::t_sts i_sts,
    output wvm_pkg::t_cmd o_cmd
);
    import wvm_pkg::*;

    t_state r_state, n_state;
    logic   w_acc;

    assign w_acc = i_tvalid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_mode == MODE_GEN) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!i_sts.skip_voice)     n_state = S_PTR;
                else if (i_sts.last_voice) n_state = S_DIV_INIT;
            end
            S_PTR:    n_state = S_RD_CUR;
            S_RD_CUR: n_state = S_RD_NXT;
            S_RD_NXT: n_state = S_INTERP;
            S_INTERP: n_state = S_MIX;
            S_MIX:    n_state = i_sts.last_voice ? S_DIV_INIT : S_LOAD;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_tready    = 1'b1;
                o_cmd.write = w_acc && i_mode != MODE_GEN;
                o_cmd.start = w_acc && i_mode == MODE_GEN;
            end
            S_LOAD: begin
                o_cmd.load       = 1'b1;
                o_cmd.next_voice = i_sts.skip_voice && !i_sts.last_voice;
            end
            S_PTR:    o_cmd.ptr    = 1'b1;
            S_RD_CUR: o_cmd.rd_cur = 1'b1;
            S_RD_NXT: o_cmd.rd_nxt = 1'b1;
            S_INTERP: o_cmd.interp = 1'b1;
            S_MIX: begin
                o_cmd.mix        = 1'b1;
                o_cmd.next_voice = !i_sts.last_voice;
            end
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_DONE:     o_cmd.out_load = !i_sts.out_busy;
            default: ;
        endcase
    end
endmodule

// ===== sv/wvm_datapath.sv =====
// Voice, descriptor and config state, sample memory, mixing arithmetic and divider.
module wvm_datapath #(
    parameter int CHANNELS      = wvm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_SLOTS  = wvm_pkg::SAMPLE_SLOTS_DEF,
    parameter int FRAC_BITS     = wvm_pkg::FRAC_BITS_DEF,
    parameter int MEM_ADDR_BITS = wvm_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wvm_pkg::t_item                      i_item,
    input  wvm_pkg::t_cmd                       i_cmd,
    input  logic                                i_cfg_we,
    input  logic [wvm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wvm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [wvm_pkg::OUT_DATA_W-1:0]      o_out_data,
    output wvm_pkg::t_sts                       o_sts
);
    import wvm_pkg::*;

    localparam int VIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SIW  = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam int PW   = 10 + FRAC_BITS;
    localparam int DCW  = $clog2(SUM_W);

    // configuration
    logic [3:0] r_active;
    logic       r_interp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 4'd4;
            r_interp <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ACTIVE) r_active <= i_cfg_data;
            if (i_cfg_index == CFG_INTERP) r_interp <= i_cfg_data[0];
        end
    end

    logic [3:0] w_n;
    always_comb begin
        if (r_active == 4'd0)                w_n = 4'd1;
        else if (32'(r_active) > CHANNELS)   w_n = 4'(CHANNELS);
        else                                 w_n = r_active;
    end

    // descriptors and voices
    logic [ADDR_W-1:0] r_dstart [SAMPLE_SLOTS];
    logic [ADDR_W-1:0] r_dend   [SAMPLE_SLOTS];
    logic [ADDR_W-1:0] r_dloop  [SAMPLE_SLOTS];
    logic [31:0]       r_vpos   [CHANNELS];
    logic [15:0]       r_vstep  [CHANNELS];
    logic [6:0]        r_vvol   [CHANNELS];
    logic [7:0]        r_vpan   [CHANNELS];
    logic [4:0]        r_vsmp   [CHANNELS];

    logic [VIW-1:0] r_vidx;
    logic [SIW-1:0] w_sidx;
    logic           w_slot_ok, w_skip;
    logic [31:0]    w_pos_adv;
    logic [VIW-1:0] w_wch;
    logic [SIW-1:0] w_wslot;

    // per-voice working registers
    logic [31:0]             r_pos;
    logic [ADDR_W-1:0]       r_start, r_end, r_loop;
    logic [6:0]              r_vol, r_gl, r_gr;
    logic [MEM_ADDR_BITS-1:0] r_ptr;
    logic [FRAC_BITS-1:0]    r_frac;
    logic [7:0]              r_cur;
    logic signed [PW-1:0]    r_prod;
    logic signed [17:0]      r_vv;
    logic signed [SUM_W-1:0] r_sum_l, r_sum_r;

    assign w_sidx    = SIW'(r_vsmp[r_vidx]);
    assign w_slot_ok = 32'(r_vsmp[r_vidx]) < SAMPLE_SLOTS;
    assign w_skip    = (r_vstep[r_vidx] == 16'd0) || !w_slot_ok ||
                       (r_dend[w_sidx] <= r_dstart[w_sidx]);
    assign w_pos_adv = r_vpos[r_vidx] + 32'(r_vstep[r_vidx]);
    assign w_wch     = VIW'(i_item.channel);
    assign w_wslot   = SIW'(i_item.sample_index);

    // pointer, wrap and stop
    logic [31:0] w_ptr0, w_ptr, w_pos_f;
    logic        w_past, w_stop;
    always_comb begin
        w_ptr0  = 32'(r_start) + (r_pos >> FRAC_BITS);
        w_past  = w_ptr0 >= 32'(r_end);
        w_ptr   = w_ptr0;
        w_pos_f = r_pos;
        w_stop  = 1'b0;
        if (w_past && r_loop != '0) begin
            w_ptr   = w_ptr0 - 32'(r_loop);
            w_pos_f = r_pos - (32'(r_loop) << FRAC_BITS);
        end else if (w_past) begin
            w_ptr  = 32'(r_end);
            w_stop = 1'b1;
        end
    end

    // pan gains
    logic [7:0] w_pan_c, w_lraw;
    logic [6:0] w_gl, w_gr;
    always_comb begin
        w_pan_c = (r_vpan[r_vidx] > 8'(PAN_FULL)) ? 8'(PAN_FULL) : r_vpan[r_vidx];
        w_lraw  = 8'(PAN_FULL) - w_pan_c;
        w_gl    = (w_lraw > 8'(GAIN_MAX)) ? 7'(GAIN_MAX) : w_lraw[6:0];
        w_gr    = (w_pan_c > 8'(GAIN_MAX)) ? 7'(GAIN_MAX) : w_pan_c[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SAMPLE_SLOTS; i++) begin
                r_dstart[i] <= '0;
                r_dend[i]   <= '0;
                r_dloop[i]  <= '0;
            end
            for (int i = 0; i < CHANNELS; i++) begin
                r_vpos[i]  <= '0;
                r_vstep[i] <= '0;
                r_vvol[i]  <= '0;
                r_vpan[i]  <= '0;
                r_vsmp[i]  <= '0;
            end
        end else begin
            if (i_cmd.write && i_item.mode == MODE_DESC &&
                32'(i_item.sample_index) < SAMPLE_SLOTS) begin
                r_dstart[w_wslot] <= i_item.address;
                r_dend[w_wslot]   <= i_item.region_end;
                r_dloop[w_wslot]  <= i_item.loop_length;
            end
            if (i_cmd.write && i_item.mode == MODE_VOICE &&
                32'(i_item.channel) < CHANNELS) begin
                r_vsmp[w_wch]  <= i_item.sample_index;
                r_vstep[w_wch] <= i_item.step;
                r_vvol[w_wch]  <= i_item.volume;
                r_vpan[w_wch]  <= i_item.panning;
                if (i_item.restart) begin
                    r_vpos[w_wch] <= 32'(i_item.start_offset) << FRAC_BITS;
                end
            end
            // advance even a silent voice
            if (i_cmd.load && !w_skip) r_vpos[r_vidx] <= w_pos_adv;
            if (i_cmd.ptr) begin
                r_vpos[r_vidx] <= w_pos_f;
                if (w_stop) r_vstep[r_vidx] <= '0;
            end
        end
    end

    // voice index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vidx <= '0;
        end else if (i_cmd.start) begin
            r_vidx <= '0;
        end else if (i_cmd.next_voice) begin
            r_vidx <= r_vidx + 1'b1;
        end
    end

    // sample memory
    logic [MEM_ADDR_BITS-1:0] w_raddr;
    logic [7:0]               w_rdata;

    assign w_raddr = i_cmd.ptr ? w_ptr[MEM_ADDR_BITS-1:0] : r_ptr + 1'b1;

    wvm_ram #(
        .WIDTH (8),
        .DEPTH (2 ** MEM_ADDR_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write && i_item.mode == MODE_MEM),
        .i_waddr (MEM_ADDR_BITS'(i_item.address)),
        .i_wdata (i_item.mem_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // arithmetic
    logic signed [8:0]       w_diff;
    logic signed [PW-1:0]    w_prod, w_prod_sh;
    logic signed [9:0]       w_v;
    logic signed [17:0]      w_vv;
    logic signed [10:0]      w_v2;
    logic signed [18:0]      w_pl, w_pr;

    always_comb begin
        w_diff    = r_interp ? ($signed({w_rdata[7], w_rdata}) - $signed({r_cur[7], r_cur}))
                             : 9'sd0;
        w_prod    = w_diff * $signed({1'b0, r_frac});
        w_prod_sh = r_prod >>> FRAC_BITS;
        w_v       = $signed({{2{r_cur[7]}}, r_cur}) + 10'(w_prod_sh);
        w_vv      = w_v * $signed({1'b0, r_vol});
        w_v2      = 11'(r_vv >>> VOL_SHIFT);
        w_pl      = w_v2 * $signed({1'b0, r_gl});
        w_pr      = w_v2 * $signed({1'b0, r_gr});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos   <= w_pos_adv;
            r_start <= r_dstart[w_sidx];
            r_end   <= r_dend[w_sidx];
            r_loop  <= r_dloop[w_sidx];
            r_vol   <= r_vvol[r_vidx];
            r_gl    <= w_gl;
            r_gr    <= w_gr;
        end
        if (i_cmd.ptr) begin
            r_ptr  <= w_ptr[MEM_ADDR_BITS-1:0];
            r_frac <= w_pos_f[FRAC_BITS-1:0];
        end
        if (i_cmd.rd_cur) r_cur  <= w_rdata;
        if (i_cmd.rd_nxt) r_prod <= w_prod;
        if (i_cmd.interp) r_vv   <= w_vv;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sum_l <= '0;
            r_sum_r <= '0;
        end else if (i_cmd.mix) begin
            r_sum_l <= r_sum_l + SUM_W'(w_pl >>> VOL_SHIFT);
            r_sum_r <= r_sum_r + SUM_W'(w_pr >>> VOL_SHIFT);
        end
    end

    // restoring divider on magnitudes, one quotient bit a cycle
    logic [SUM_W-1:0] r_dq_l, r_dq_r;
    logic [3:0]       r_rem_l, r_rem_r;
    logic             r_neg_l, r_neg_r;
    logic [DCW-1:0]   r_dcnt;
    logic [4:0]       w_tl, w_tr;

    assign w_tl = {r_rem_l, r_dq_l[SUM_W-1]};
    assign w_tr = {r_rem_r, r_dq_r[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg_l <= r_sum_l[SUM_W-1];
            r_neg_r <= r_sum_r[SUM_W-1];
            r_dq_l  <= r_sum_l[SUM_W-1] ? SUM_W'(-r_sum_l) : SUM_W'(r_sum_l);
            r_dq_r  <= r_sum_r[SUM_W-1] ? SUM_W'(-r_sum_r) : SUM_W'(r_sum_r);
            r_rem_l <= '0;
            r_rem_r <= '0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (w_tl >= {1'b0, w_n}) begin
                r_rem_l <= 4'(w_tl - {1'b0, w_n});
                r_dq_l  <= {r_dq_l[SUM_W-2:0], 1'b1};
            end else begin
                r_rem_l <= w_tl[3:0];
                r_dq_l  <= {r_dq_l[SUM_W-2:0], 1'b0};
            end
            if (w_tr >= {1'b0, w_n}) begin
                r_rem_r <= 4'(w_tr - {1'b0, w_n});
                r_dq_r  <= {r_dq_r[SUM_W-2:0], 1'b1};
            end else begin
                r_rem_r <= w_tr[3:0];
                r_dq_r  <= {r_dq_r[SUM_W-2:0], 1'b0};
            end
        end
    end

    // sign, bias and clamp
    logic signed [SUM_W:0]    w_bl, w_br;
    logic [OUT_BITS-1:0]      w_ol, w_or;
    always_comb begin
        w_bl = (r_neg_l ? -$signed({1'b0, r_dq_l}) : $signed({1'b0, r_dq_l}))
               + (SUM_W+1)'(OUT_BIAS);
        w_br = (r_neg_r ? -$signed({1'b0, r_dq_r}) : $signed({1'b0, r_dq_r}))
               + (SUM_W+1)'(OUT_BIAS);
        if (w_bl < 0)                        w_ol = '0;
        else if (w_bl > (SUM_W+1)'(255))     w_ol = '1;
        else                                 w_ol = w_bl[OUT_BITS-1:0];
        if (w_br < 0)                        w_or = '0;
        else if (w_br > (SUM_W+1)'(255))     w_or = '1;
        else                                 w_or = w_br[OUT_BITS-1:0];
    end

    // output register
    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) o_out_data <= {w_or, w_ol};
    end

    assign o_out_valid = r_out_valid;

    assign o_sts.skip_voice = w_skip || (r_vvol[r_vidx] == 7'd0);
    assign o_sts.last_voice = (32'(r_vidx) + 32'd1) == 32'(w_n);
    assign o_sts.div_last   = r_dcnt == DCW'(SUM_W - 1);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;
endmodule

// ===== sv/wavetable_voice_mixer_top.sv =====
// Top level of the wavetable voice mixer: ports, beat unpacking, sequencer and datapath.
//
//  channel   dir  tdata / payload                        tuser
//  s_axis    in   item fields (see port comment)         mode
//  m_axis    out  left_sample, right_sample              -
//  cfg       in   i_cfg_we / i_cfg_index / i_cfg_data    -
//
// Write beats (modes 0..2) leave the input ready. A generate beat closes it until
// its result is loaded; a silent or idle voice is only loaded, while for a mixed
// voice the two sample-memory reads and the multiply chain set the cost, and the
// 16-step divider sets the tail.
// Reset is synchronous; all voices, descriptors and config return to defaults.
// A held result does not block the next beat; only the final load waits for it.
module wavetable_voice_mixer_top #(
    parameter int CHANNELS      = wvm_pkg::CHANNELS_DEF,
    parameter int SAMPLE_SLOTS  = wvm_pkg::SAMPLE_SLOTS_DEF,
    parameter int FRAC_BITS     = wvm_pkg::FRAC_BITS_DEF,
    parameter int MEM_ADDR_BITS = wvm_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // address, mem_byte, sample_index, region_end, loop_length, channel,
    // step, volume, panning, restart, start_offset
    input  logic [wvm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic [wvm_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // left_sample, right_sample
    output logic [wvm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [wvm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wvm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wvm_pkg::*;

    t_item w_item;
    t_cmd  w_cmd;
    t_sts  w_sts;

    always_comb begin
        w_item.mode         = s_axis_tuser;
        w_item.address      = s_axis_tdata[16:0];
        w_item.mem_byte     = s_axis_tdata[24:17];
        w_item.sample_index = s_axis_tdata[29:25];
        w_item.region_end   = s_axis_tdata[46:30];
        w_item.loop_length  = s_axis_tdata[63:47];
        w_item.channel      = s_axis_tdata[66:64];
        w_item.step         = s_axis_tdata[82:67];
        w_item.volume       = s_axis_tdata[89:83];
        w_item.panning      = s_axis_tdata[97:90];
        w_item.restart      = s_axis_tdata[98];
        w_item.start_offset = s_axis_tdata[114:99];
    end

    wvm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .i_mode   (s_axis_tuser),
        .o_tready (s_axis_tready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    wvm_datapath #(
        .CHANNELS      (CHANNELS),
        .SAMPLE_SLOTS  (SAMPLE_SLOTS),
        .FRAC_BITS     (FRAC_BITS),
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_sts       (w_sts)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over a held beat");

    a_gen_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> !s_axis_tready)
        else $error("input open during generate");

    a_div_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_step && w_sts.div_last) |=> !s_axis_tready)
        else $error("input open before result load");
endmodule

// ===== dv/wvm_checker.sv =====
// Checker for the wavetable voice mixer: predicts mixed samples and compares output beats.
`timescale 1ns / 1ps

module wvm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [wvm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [wvm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [wvm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [wvm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wvm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import wvm_pkg::*;

    localparam int NCH  = CHANNELS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;

    logic signed [7:0] smem [0:(1<<MEM_ADDR_BITS_DEF)-1];
    logic [16:0]  dsc_start [SAMPLE_SLOTS_DEF];
    logic [16:0]  dsc_end   [SAMPLE_SLOTS_DEF];
    logic [16:0]  dsc_loop  [SAMPLE_SLOTS_DEF];
    logic [31:0]  vc_pos  [NCH];
    logic [15:0]  vc_step [NCH];
    logic [6:0]   vc_vol  [NCH];
    logic [7:0]   vc_pan  [NCH];
    logic [4:0]   vc_smp  [NCH];
    logic [3:0]   mix_count;
    logic         interp_on;
    logic [15:0]  frame_q [$];

    assign o_pending = frame_q.size();

    // Advance all mixed voices one output sample and return the biased left/right pair.
    function automatic logic [15:0] mix_frame();
        int n, sl, sr, v, nx, frac, pan, gl, gr, lo, ro;
        logic [31:0] ptr;
        logic [4:0]  s;
        n = (mix_count == 0) ? 1 : ((mix_count > NCH) ? NCH : int'(mix_count));
        sl = 0;
        sr = 0;
        for (int c = 0; c < n; c++) begin
            s = vc_smp[c];
            if (vc_step[c] == 0 || dsc_end[s] <= dsc_start[s]) continue;
            vc_pos[c] = vc_pos[c] + 32'(vc_step[c]);
            if (vc_vol[c] == 0) continue;
            ptr = 32'(dsc_start[s]) + (vc_pos[c] >> FRAC);
            if (dsc_loop[s] != 0) begin
                if (ptr >= 32'(dsc_end[s])) begin
                    vc_pos[c] = vc_pos[c] - (32'(dsc_loop[s]) << FRAC);
                    ptr = ptr - 32'(dsc_loop[s]);
                end
            end else if (ptr >= 32'(dsc_end[s])) begin
                vc_step[c] = '0;
                ptr = 32'(dsc_end[s]);
            end
            v = smem[ptr[16:0]];
            if (interp_on) begin
                nx = smem[ptr[16:0] + 17'd1];
                frac = int'(vc_pos[c][FRAC-1:0]);
                v = v + (((nx - v) * frac) >>> FRAC);
            end
            v = (v * int'(vc_vol[c])) >>> VOL_SHIFT;
            pan = (vc_pan[c] > PAN_FULL) ? PAN_FULL : int'(vc_pan[c]);
            gl = (PAN_FULL - pan > GAIN_MAX) ? GAIN_MAX : PAN_FULL - pan;
            gr = (pan > GAIN_MAX) ? GAIN_MAX : pan;
            sl += (v * gl) >>> VOL_SHIFT;
            sr += (v * gr) >>> VOL_SHIFT;
        end
        lo = sl / n + OUT_BIAS;
        ro = sr / n + OUT_BIAS;
        lo = (lo < 0) ? 0 : ((lo > 255) ? 255 : lo);
        ro = (ro < 0) ? 0 : ((ro > 255) ? 255 : ro);
        return {ro[7:0], lo[7:0]};
    endfunction

    always @(posedge i_clk) begin
        logic [4:0]  pad;
        logic [16:0] f_addr, f_end, f_loop;
        logic [7:0]  f_byte, f_pan;
        logic [4:0]  f_smp;
        logic [2:0]  f_ch;
        logic [15:0] f_step, f_off, exp_frame;
        logic [6:0]  f_vol;
        logic        f_rst;
        if (!i_rst_n) begin
            foreach (smem[a]) smem[a] = '0;
            foreach (dsc_start[k]) begin
                dsc_start[k] = '0;
                dsc_end[k]   = '0;
                dsc_loop[k]  = '0;
            end
            foreach (vc_pos[k]) begin
                vc_pos[k]  = '0;
                vc_step[k] = '0;
                vc_vol[k]  = '0;
                vc_pan[k]  = '0;
                vc_smp[k]  = '0;
            end
            mix_count = 4'd4;
            interp_on = 1'b0;
            frame_q.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE: mix_count = i_cfg_data[3:0];
                    CFG_INTERP: interp_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                o_checked++;
                if (frame_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected output beat %h", $time, m_axis_tdata);
                end else begin
                    exp_frame = frame_q.pop_front();
                    if (m_axis_tdata[7:0] !== exp_frame[7:0]
                            || m_axis_tdata[15:8] !== exp_frame[15:8]) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mix mismatch left exp %0d got %0d, right exp %0d got %0d",
                                     $time, exp_frame[7:0], m_axis_tdata[7:0],
                                     exp_frame[15:8], m_axis_tdata[15:8]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                {pad, f_off, f_rst, f_pan, f_vol, f_step, f_ch, f_loop, f_end, f_smp,
                 f_byte, f_addr} = s_axis_tdata;
                case (s_axis_tuser)
                    MODE_MEM: smem[f_addr] = f_byte;
                    MODE_DESC: begin
                        dsc_start[f_smp] = f_addr;
                        dsc_end[f_smp]   = f_end;
                        dsc_loop[f_smp]  = f_loop;
                    end
                    MODE_VOICE: begin
                        vc_smp[f_ch]  = f_smp;
                        vc_step[f_ch] = f_step;
                        vc_vol[f_ch]  = f_vol;
                        vc_pan[f_ch]  = f_pan;
                        if (f_rst) vc_pos[f_ch] = 32'(f_off) << FRAC;
                    end
                    default: frame_q.push_back(mix_frame());
                endcase
            end
        end
    end

endmodule

// ===== dv/tb_wavetable_voice_mixer_top.sv =====
// Testbench top for the wavetable voice mixer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_wavetable_voice_mixer_top;
    import wvm_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // address, mem_byte, sample_index, region_end, loop_length, channel,
    // step, volume, panning, restart, start_offset
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // mode
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // left_sample, right_sample
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors, pending, checked;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;

    wavetable_voice_mixer_top dut (.*);

    wvm_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_index,
        .i_cfg_data, .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("timeout with %0d samples outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic t_item noise_item();
        t_item it;
        it.mode = MODE_GEN;
        it.address = 17'($urandom);
        it.mem_byte = 8'($urandom);
        it.sample_index = 5'($urandom);
        it.region_end = 17'($urandom);
        it.loop_length = 17'($urandom);
        it.channel = 3'($urandom);
        it.step = 16'($urandom);
        it.volume = 7'($urandom);
        it.panning = 8'($urandom);
        it.restart = 1'($urandom);
        it.start_offset = 16'($urandom);
        return it;
    endfunction

    function automatic t_item mem_item(int addr, logic [7:0] b);
        t_item it = noise_item();
        it.mode = MODE_MEM;
        it.address = 17'(addr);
        it.mem_byte = b;
        return it;
    endfunction

    function automatic t_item desc_item(int slot, int start, int stop, int loop);
        t_item it = noise_item();
        it.mode = MODE_DESC;
        it.sample_index = 5'(slot);
        it.address = 17'(start);
        it.region_end = 17'(stop);
        it.loop_length = 17'(loop);
        return it;
    endfunction

    function automatic t_item voice_item(int ch, int smp, int stp, int vol, int pan,
                                         bit rst, int off);
        t_item it = noise_item();
        it.mode = MODE_VOICE;
        it.channel = 3'(ch);
        it.sample_index = 5'(smp);
        it.step = 16'(stp);
        it.volume = 7'(vol);
        it.panning = 8'(pan);
        it.restart = rst;
        it.start_offset = 16'(off);
        return it;
    endfunction

    // Regions stay inside the low 256 written bytes. Loops of at least 16 bytes always
    // pull back a voice that moves under 16 bytes a sample, and every voice write
    // restarts near the region start, so no read leaves the written bytes.
    function automatic t_item random_item();
        t_item it = noise_item();
        int r, len, start;
        r = $urandom_range(99);
        if (r < 10) begin
            it.mode = MODE_MEM;
        end else if (r < 22) begin
            it.mode = MODE_DESC;
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(16, 48);
                start = $urandom_range(0, 150);
                it.address = 17'(start);
                it.region_end = 17'(start + len);
                it.loop_length = $urandom_range(1) ? 17'd0 : 17'($urandom_range(16, len));
            end else begin
                it.region_end = it.address;
            end
        end else if (r < 45) begin
            it.mode = MODE_VOICE;
            r = $urandom_range(99);
            if (r < 70) it.step = 16'($urandom_range(1, 20000));
            else if (r < 80) it.step = '0;
            if ($urandom_range(99) < 80) it.volume = 7'($urandom_range(0, GAIN_MAX));
            if ($urandom_range(1)) it.panning = 8'($urandom_range(0, PAN_FULL));
            it.restart = 1'b1;
            it.start_offset = 16'($urandom_range(0, 31));
        end
        return it;
    endfunction

    task automatic send_item(input t_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {5'b0, it.start_offset, it.restart, it.panning, it.volume, it.step,
                          it.channel, it.loop_length, it.region_end, it.sample_index,
                          it.mem_byte, it.address};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Hold off until every predicted sample has drained, then let a generate finish.
    task automatic drain();
        int guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int actives[10] = '{8, 1, 0, 15, 3, 5, 2, 7, 4, 6};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the bytes that any voice can reach: the low region and the top end.
        for (int a = 0; a < 256; a++)
            send_item(mem_item(a, 8'($urandom)));
        for (int a = 130990; a < 131072; a++)
            send_item(mem_item(a, 8'($urandom)));
        drain();
        write_reg(CFG_ACTIVE, 8);
        write_reg(CFG_INTERP, 1);

        send_item(mem_item(0, 8'h7f));
        send_item(mem_item(1, 8'h80));
        send_item(mem_item(131071, 8'h80));
        send_item(desc_item(0, 0, 16, 16));
        send_item(desc_item(1, 100, 140, 0));
        send_item(desc_item(31, 131060, 131071, 0));
        send_item(desc_item(2, 50, 50, 0));
        send_item(desc_item(3, 0, 10, 30));
        send_item(voice_item(0, 0, 4096, 64, 0, 1, 14));
        send_item(voice_item(1, 1, 65535, 64, 128, 1, 0));
        send_item(voice_item(2, 31, 2048, 127, 255, 1, 10));
        send_item(voice_item(3, 3, 8192, 64, 64, 1, 8));
        send_item(voice_item(4, 2, 100, 10, 20, 1, 0));
        send_item(voice_item(5, 0, 0, 64, 90, 0, 0));
        send_item(voice_item(6, 0, 1000, 0, 40, 1, 3));
        send_item(voice_item(7, 1, 300, 40, 30, 1, 65535));
        repeat (3) send_item(noise_item());
        drain();

        // Park every voice and move the wrapping regions back into low memory.
        send_item(desc_item(3, 10, 40, 16));
        send_item(desc_item(31, 60, 100, 0));
        for (int c = 0; c < 8; c++)
            send_item(voice_item(c, 0, 0, 64, 64, 1, 0));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            send_idle_pct = (ph < 3) ? 13 : ((ph < 6) ? 48 : 0);
            recv_idle_pct = (ph < 3) ? 48 : ((ph < 6) ? 13 : 0);
            write_reg(CFG_ACTIVE, actives[ph]);
            write_reg(CFG_INTERP, (ph % 2 == 0) ? 1 : 0);
            write_reg(2'($urandom_range(2, 3)), $urandom);
            repeat (48) send_item(random_item());
            drain();
        end

        repeat (400) @(negedge i_clk);
        $display("Sent %0d beats (sample fill, wrap/stop/saturation cases, 480 random items).",
                 items_sent);
        $display("Checked %0d mixed samples over ten channel-count/interpolation settings.",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d samples never arrived", errors, pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/wvm_pkg.sv
sv/wvm_ram.sv
sv/wvm_ctrl.sv
sv/wvm_datapath.sv
sv/wavetable_voice_mixer_top.sv
dv/wvm_checker.sv
dv/tb_wavetable_voice_mixer_top.sv
